// ===== design/dlp_pkg.sv =====
package dlp_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOTTS  = 3'd1,
        ST_MONTH  = 3'd2,
        ST_DAY    = 3'd3,
        ST_HOUR   = 3'd4,
        ST_MINUTE = 3'd5,
        ST_SECOND = 3'd6
    } status_t;

    // parser state carried from one byte to the next
    typedef struct packed {
        logic        active;
        logic [3:0]  phase;
        logic [1:0]  digit_idx;
        logic [13:0] year_acc;
        logic [6:0]  month_acc;
        logic [6:0]  day_acc;
        logic [6:0]  hour_acc;
        logic [6:0]  minute_acc;
        logic [6:0]  second_acc;
        logic [31:0] nano_acc;
        logic [7:0]  length_count;
    } dlp_state_t;

    // one parse result
    typedef struct packed {
        status_t     status;
        logic        has_time;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
        logic [31:0] nanoseconds;
        logic [7:0]  consumed_length;
    } dlp_result_t;

    localparam int unsigned DATA_W   = 80;
    localparam int unsigned USER_W   = 4;
    localparam logic [7:0]  LEN_MAX  = 8'hFF;
    localparam logic [31:0] NANO_MAX = 32'hFFFF_FFFF;

endpackage

// ===== design/dlp_step.sv =====
module dlp_step (
    input  dlp_pkg::dlp_state_t  state_cur,
    input  logic [7:0]           char_byte,
    input  logic                 start_token,
    output dlp_pkg::dlp_state_t  state_next,
    output logic                 emit,
    output dlp_pkg::dlp_result_t result
);

    // parse phases
    localparam logic [3:0] PH_YEAR     = 4'd0;
    localparam logic [3:0] PH_DOT1     = 4'd1;
    localparam logic [3:0] PH_MONTH    = 4'd2;
    localparam logic [3:0] PH_DOT2     = 4'd3;
    localparam logic [3:0] PH_DAY      = 4'd4;
    localparam logic [3:0] PH_DATE_END = 4'd5;
    localparam logic [3:0] PH_HOUR     = 4'd6;
    localparam logic [3:0] PH_COLON1   = 4'd7;
    localparam logic [3:0] PH_MINUTE   = 4'd8;
    localparam logic [3:0] PH_COLON2   = 4'd9;
    localparam logic [3:0] PH_SECOND   = 4'd10;
    localparam logic [3:0] PH_DOT3     = 4'd11;
    localparam logic [3:0] PH_FRAC1    = 4'd12;
    localparam logic [3:0] PH_FRAC    = 4'd13;

    dlp_pkg::dlp_state_t cur;
    dlp_pkg::dlp_state_t nxt;
    dlp_pkg::status_t    st;
    dlp_pkg::status_t    field_err;
    logic                num_char;
    logic [3:0]          digit;
    logic [7:0]          len_bump;
    logic [6:0]          field_acc;
    logic [6:0]          field_new;
    logic [6:0]          field_limit;
    logic [7:0]          sep_char;
    logic [35:0]         nano_wide;
    logic [31:0]         nano_sat;
    logic                ok;
    logic                timed;

    always_comb begin
        cur = state_cur;
        if (start_token) begin
            cur        = '0;
            cur.active = 1'b1;
        end
    end

    assign num_char = char_byte inside {[8'h30:8'h39]};
    assign digit    = num_char ? char_byte[3:0] : 4'd0;
    assign len_bump = (cur.length_count == dlp_pkg::LEN_MAX) ? cur.length_count
                                                             : cur.length_count + 8'd1;
    assign sep_char = (cur.phase == PH_COLON1 || cur.phase == PH_COLON2) ? 8'h3A : 8'h2E;

    // two-digit field selection
    always_comb begin
        field_acc   = cur.month_acc;
        field_limit = 7'd12;
        field_err   = dlp_pkg::ST_MONTH;
        case (cur.phase)
            PH_MONTH: begin
                field_acc   = cur.month_acc;
                field_limit = 7'd12;
                field_err   = dlp_pkg::ST_MONTH;
            end
            PH_DAY: begin
                field_acc   = cur.day_acc;
                field_limit = 7'd31;
                field_err   = dlp_pkg::ST_DAY;
            end
            PH_HOUR: begin
                field_acc   = cur.hour_acc;
                field_limit = 7'd23;
                field_err   = dlp_pkg::ST_HOUR;
            end
            PH_MINUTE: begin
                field_acc   = cur.minute_acc;
                field_limit = 7'd59;
                field_err   = dlp_pkg::ST_MINUTE;
            end
            PH_SECOND: begin
                field_acc   = cur.second_acc;
                field_limit = 7'd59;
                field_err   = dlp_pkg::ST_SECOND;
            end
            default: begin
                field_acc   = cur.month_acc;
                field_limit = 7'd12;
                field_err   = dlp_pkg::ST_MONTH;
            end
        endcase
    end

    assign field_new = field_acc * 7'd10 + {3'd0, digit};

    // fraction times ten plus digit, clamped to 32 bits
    assign nano_wide = ({4'd0, cur.nano_acc} << 3) + ({4'd0, cur.nano_acc} << 1)
                     + {32'd0, digit};
    assign nano_sat  = (nano_wide[35:32] != 4'd0) ? dlp_pkg::NANO_MAX : nano_wide[31:0];

    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        st   = dlp_pkg::ST_OK;
        if (cur.active) begin
            case (cur.phase)
                PH_YEAR: begin
                    if (!num_char) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_NOTTS;
                    end else begin
                        nxt.year_acc     = cur.year_acc * 14'd10 + {10'd0, digit};
                        nxt.length_count = len_bump;
                        if (cur.digit_idx == 2'd3) begin
                            nxt.digit_idx = 2'd0;
                            nxt.phase     = PH_DOT1;
                        end else begin
                            nxt.digit_idx = cur.digit_idx + 2'd1;
                        end
                    end
                end
                PH_DOT1, PH_DOT2, PH_COLON1, PH_COLON2, PH_DOT3: begin
                    if (char_byte != sep_char) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_NOTTS;
                    end else begin
                        nxt.length_count = len_bump;
                        nxt.phase        = cur.phase + 4'd1;
                    end
                end
                PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
                    if (!num_char) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_NOTTS;
                    end else begin
                        nxt.length_count = len_bump;
                        case (cur.phase)
                            PH_MONTH:  nxt.month_acc  = field_new;
                            PH_DAY:    nxt.day_acc    = field_new;
                            PH_HOUR:   nxt.hour_acc   = field_new;
                            PH_MINUTE: nxt.minute_acc = field_new;
                            default:   nxt.second_acc = field_new;
                        endcase
                        if (cur.digit_idx == 2'd0) begin
                            nxt.digit_idx = 2'd1;
                        end else begin
                            nxt.digit_idx = 2'd0;
                            if (field_new > field_limit) begin
                                emit = 1'b1;
                                st   = field_err;
                            end else begin
                                nxt.phase = cur.phase + 4'd1;
                            end
                        end
                    end
                end
                PH_DATE_END: begin
                    if (char_byte != 8'h44) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_OK;
                    end else begin
                        nxt.length_count = len_bump;
                        nxt.phase        = PH_HOUR;
                    end
                end
                PH_FRAC1: begin
                    if (!num_char) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_NOTTS;
                    end else begin
                        nxt.nano_acc     = {28'd0, digit};
                        nxt.length_count = len_bump;
                        nxt.phase        = PH_FRAC;
                    end
                end
                PH_FRAC: begin
                    if (!num_char) begin
                        emit = 1'b1;
                        st   = dlp_pkg::ST_OK;
                    end else begin
                        nxt.nano_acc     = nano_sat;
                        nxt.length_count = len_bump;
                    end
                end
                default: begin
                    emit = 1'b1;
                    st   = dlp_pkg::ST_NOTTS;
                end
            endcase
            if (emit) begin
                nxt.active = 1'b0;
            end
        end
    end

    assign ok    = (st == dlp_pkg::ST_OK);
    assign timed = ok && (nxt.phase >= PH_HOUR);

    always_comb begin
        result.status          = st;
        result.has_time        = timed;
        result.year            = ok ? nxt.year_acc : 14'd0;
        result.month           = ok ? nxt.month_acc[3:0] : 4'd0;
        result.day             = ok ? nxt.day_acc[4:0] : 5'd0;
        result.hours           = timed ? nxt.hour_acc[4:0] : 5'd0;
        result.minutes         = timed ? nxt.minute_acc[5:0] : 6'd0;
        result.seconds         = timed ? nxt.second_acc[5:0] : 6'd0;
        result.nanoseconds     = timed ? nxt.nano_acc : 32'd0;
        result.consumed_length = nxt.length_count;
    end

    assign state_next = nxt;

endmodule

// ===== design/datetime_literal_parser_unit.sv =====
// channel | dir | tdata (low bit up)                  | tuser (low bit up)
// s_      | in  | char_byte[7:0]                      | start_token[0]
// m_      | out | year, month, day, hours, minutes,   | status[2:0], has_time[3]
//         |     | seconds, nanoseconds, consumed_len  |
//
// one byte per cycle sustained while no result is stalled; each byte passes an
// input register, then the parser step logic into the result register
// the byte-to-byte parser state updates in the same cycle the byte is consumed
// aresetn is synchronous, active low; it empties both registers and idles the parser
// a stalled result holds the result register, and the input register keeps
// accepting as long as the held byte can move on
module datetime_literal_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte[7:0]
    input  logic [0:0]  s_tuser,   // start_token[0]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // year[13:0], month[17:14], day[22:18], hours[27:23],
                                   // minutes[33:28], seconds[39:34], nanoseconds[71:40],
                                   // consumed_length[79:72]
    output logic [3:0]  m_tuser    // status[2:0], has_time[3]
);

    // input register
    logic                 in_vld_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_start_reg;

    // parser state, carried between bytes
    dlp_pkg::dlp_state_t  state_reg;
    dlp_pkg::dlp_state_t  state_next;

    // result register
    logic                 out_vld_reg;
    dlp_pkg::dlp_result_t out_res_reg;

    logic                 step_emit;
    dlp_pkg::dlp_result_t step_res;
    logic                 advance;

    // the held byte moves on when the result slot is free or being emptied
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    dlp_step u_step (
        .state_cur   (state_reg),
        .char_byte   (in_byte_reg),
        .start_token (in_start_reg),
        .state_next  (state_next),
        .emit        (step_emit),
        .result      (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg   <= state_next;
                out_vld_reg <= step_emit;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance && step_emit) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = {out_res_reg.has_time, out_res_reg.status};
    assign m_tdata  = {out_res_reg.consumed_length,
                       out_res_reg.nanoseconds,
                       out_res_reg.seconds,
                       out_res_reg.minutes,
                       out_res_reg.hours,
                       out_res_reg.day,
                       out_res_reg.month,
                       out_res_reg.year};

`ifndef NO_ASSERTIONS
    // a good literal holds at least the full date
    a_ok_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] == dlp_pkg::ST_OK) |-> (m_tdata[79:72] >= 8'd10))
        else $error("ok result shorter than a date");

    // a time part needs a good status and the whole time text
    a_time_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |->
            (m_tuser[2:0] == dlp_pkg::ST_OK && m_tdata[79:72] >= 8'd21))
        else $error("time flag on short or failed result");

    // failed parses carry only the length
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2:0] != dlp_pkg::ST_OK) |->
            (m_tdata[71:0] == 72'd0 && !m_tuser[3]))
        else $error("error result with nonzero fields");

    // parser state only moves when a byte is consumed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("parser state changed without a byte");

    // a byte waiting behind a stalled result is not lost
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |=> in_vld_reg)
        else $error("held byte dropped during stall");
`endif

endmodule
